>>> src/slpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpt_pkg
// Shared widths, register codes and payload types of the line point test.
// ----------------------------------------------------------------------------
package slpt_pkg;

    // field widths
    localparam int COORD_WIDTH = 12;
    localparam int GRAY_W      = 8;
    localparam int DERIV_W     = 20;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int LIMIT_FRAC  = 8;

    // datapath widths
    localparam int DIFF_W = DERIV_W + 1;          // a - c
    localparam int DD_W   = 2 * DIFF_W;           // d*d + 4*b*b
    localparam int SQRT_W = DIFF_W;               // floor sqrt of dd
    localparam int TRY_W  = DD_W + 2;             // sqrt trial value
    localparam int V_W    = DIFF_W + 2;           // raw eigenvector component
    localparam int NV_W   = 16;                   // normalized magnitude
    localparam int SH_W   = 3;                    // normalize shift count
    localparam int SQ_W   = 2 * (NV_W + 1);       // vx*vx and friends
    localparam int PG_W   = NV_W + 1 + DERIV_W;   // v*g
    localparam int P_W    = PG_W + 1;             // p
    localparam int QT_W   = DERIV_W + SQ_W;       // hessian term
    localparam int Q_W    = QT_W + 2;             // q
    localparam int AQ_W   = Q_W - 1;              // |q|
    localparam int AP_W   = PG_W;                 // |p|
    localparam int EX_W   = AP_W + NV_W;          // |p|*|v|
    localparam int LIM_W  = CFG_DATA_W + AQ_W;    // limit*|q|

    // register reset values
    localparam logic [CFG_DATA_W-1:0] THRESH_RST = 8'd200;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RST  = 8'd128;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH = 4'd0,
        CFG_LIMIT  = 4'd1
    } t_cfg_idx;

    // payload that travels along the pipeline
    typedef struct packed {
        logic signed [DERIV_W-1:0] a;
        logic signed [DERIV_W-1:0] b;
        logic signed [DERIV_W-1:0] c;
        logic signed [DERIV_W-1:0] gx;
        logic signed [DERIV_W-1:0] gy;
        logic [COORD_WIDTH-1:0]    col;
        logic [COORD_WIDTH-1:0]    row;
        logic signed [DIFF_W-1:0]  d;
        logic                      sum_neg;
        logic                      dd_zero;
    } t_pay;

endpackage
`default_nettype wire

>>> src/slpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpt_if
// Channel interfaces: pixel words in, point words out, register writes.
// ----------------------------------------------------------------------------
interface slpt_pix_if import slpt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [GRAY_W-1:0]         gray;
    logic [COORD_WIDTH-1:0]    col;
    logic [COORD_WIDTH-1:0]    row;
    logic signed [DERIV_W-1:0] grad_x;
    logic signed [DERIV_W-1:0] grad_y;
    logic signed [DERIV_W-1:0] hess_xx;
    logic signed [DERIV_W-1:0] hess_yy;
    logic signed [DERIV_W-1:0] hess_xy;

    modport source (output valid, gray, col, row, grad_x, grad_y, hess_xx, hess_yy,
                    hess_xy, input ready);
    modport sink   (input valid, gray, col, row, grad_x, grad_y, hess_xx, hess_yy,
                    hess_xy, output ready);
endinterface

interface slpt_pt_if import slpt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] out_col;
    logic [COORD_WIDTH-1:0] out_row;

    modport source (output valid, out_col, out_row, input ready);
    modport sink   (input valid, out_col, out_row, output ready);
endinterface

interface slpt_cfg_if import slpt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/steger_line_point_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// steger_line_point_test
// Per-pixel line-centre test on the Hessian of the blurred image.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns the pixel's column and row when
// the pixel is brighter than the threshold and its sub-pixel offset along the
// dominant Hessian eigenvector stays within the offset limit on both axes.
// Rejected pixels give no word. From accept to the output register the
// stages are: input register, discriminant, 21 one-bit square root
// stages, eigenvector, normalize, products, hessian terms, |p| and |q|,
// limit products, output. The whole pipeline advances together and holds
// only while the output word waits; register writes take effect at once.
// ----------------------------------------------------------------------------
module steger_line_point_test import slpt_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    slpt_pix_if.sink     i_pix,
    slpt_pt_if.source    o_pt,
    slpt_cfg_if.sink     i_cfg
);

    logic w_adv;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_cfg_thresh;
    logic [CFG_DATA_W-1:0] r_cfg_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thresh <= THRESH_RST;
            r_cfg_limit  <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_THRESH: r_cfg_thresh <= i_cfg.data;
                CFG_LIMIT:  r_cfg_limit  <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    // pipeline advances unless the output word is stalled
    logic r_out_valid;
    assign w_adv       = !r_out_valid || o_pt.ready;
    assign i_pix.ready = w_adv;

    // stage 1: input register and brightness test
    logic r1_vld;
    logic signed [DERIV_W-1:0] r1_a, r1_b, r1_c, r1_gx, r1_gy;
    logic [COORD_WIDTH-1:0] r1_col, r1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_adv) r1_vld <= i_pix.valid && (i_pix.gray > r_cfg_thresh);
        if (w_adv) begin
            r1_a   <= i_pix.hess_xx;
            r1_b   <= i_pix.hess_xy;
            r1_c   <= i_pix.hess_yy;
            r1_gx  <= i_pix.grad_x;
            r1_gy  <= i_pix.grad_y;
            r1_col <= i_pix.col;
            r1_row <= i_pix.row;
        end
    end

    // stage 2: discriminant d*d + 4*b*b
    logic signed [DIFF_W-1:0] w_d, w_sum;
    logic signed [DD_W-1:0]   w_dsq;
    logic signed [DD_W-3:0]   w_bsq;
    logic [DD_W-1:0]          w_dd;

    assign w_d   = DIFF_W'(r1_a) - DIFF_W'(r1_c);
    assign w_sum = DIFF_W'(r1_a) + DIFF_W'(r1_c);
    assign w_dsq = w_d * w_d;
    assign w_bsq = r1_b * r1_b;
    assign w_dd  = $unsigned(w_dsq) + {$unsigned(w_bsq), 2'b00};

    logic          r2_vld;
    logic [DD_W-1:0] r2_dd;
    t_pay          r2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_adv) r2_vld <= r1_vld;
        if (w_adv) begin
            r2_dd          <= w_dd;
            r2_pay.a       <= r1_a;
            r2_pay.b       <= r1_b;
            r2_pay.c       <= r1_c;
            r2_pay.gx      <= r1_gx;
            r2_pay.gy      <= r1_gy;
            r2_pay.col     <= r1_col;
            r2_pay.row     <= r1_row;
            r2_pay.d       <= w_d;
            r2_pay.sum_neg <= w_sum[DIFF_W-1];
            r2_pay.dd_zero <= (w_dd == '0);
        end
    end

    // square root stages, one result bit each, most significant first
    logic                r_sq_vld  [SQRT_W];
    logic [DD_W-1:0]     r_sq_rem  [SQRT_W];
    logic [SQRT_W-1:0]   r_sq_root [SQRT_W];
    t_pay                r_sq_pay  [SQRT_W];

    for (genvar gi = 0; gi < SQRT_W; gi++) begin : g_sqrt
        localparam int K = SQRT_W - 1 - gi;
        logic              w_vld;
        logic [DD_W-1:0]   w_rem;
        logic [SQRT_W-1:0] w_root;
        t_pay              w_pay;
        logic [TRY_W-1:0]  w_try;
        logic              w_take;

        if (gi == 0) begin : g_first
            assign w_vld  = r2_vld;
            assign w_rem  = r2_dd;
            assign w_root = '0;
            assign w_pay  = r2_pay;
        end else begin : g_next
            assign w_vld  = r_sq_vld[gi-1];
            assign w_rem  = r_sq_rem[gi-1];
            assign w_root = r_sq_root[gi-1];
            assign w_pay  = r_sq_pay[gi-1];
        end

        // (r + 2^k)^2 - r^2 = 2^(k+1) r + 2^(2k)
        assign w_try  = (TRY_W'(w_root) << (K + 1)) + (TRY_W'(1) << (2 * K));
        assign w_take = TRY_W'(w_rem) >= w_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_vld[gi] <= 1'b0;
            else if (w_adv) r_sq_vld[gi] <= w_vld;
            if (w_adv) begin
                r_sq_rem[gi]  <= w_take ? w_rem - DD_W'(w_try) : w_rem;
                r_sq_root[gi] <= w_take ? (w_root | (SQRT_W'(1) << K)) : w_root;
                r_sq_pay[gi]  <= w_pay;
            end
        end
    end

    // eigenvector stage
    logic              w_sq_vld;
    logic [SQRT_W-1:0] w_s;
    t_pay              w_sq_pay;
    logic signed [V_W-1:0] w_dv, w_sv, w_b2, n_vx, n_vy;

    assign w_sq_vld = r_sq_vld[SQRT_W-1];
    assign w_s      = r_sq_root[SQRT_W-1];
    assign w_sq_pay = r_sq_pay[SQRT_W-1];
    assign w_dv     = V_W'(w_sq_pay.d);
    assign w_sv     = $signed(V_W'(w_s));
    assign w_b2     = V_W'(w_sq_pay.b) <<< 1;

    always_comb begin
        if (w_sq_pay.dd_zero) begin
            n_vx = V_W'(1);
            n_vy = '0;
        end else if (!w_sq_pay.sum_neg) begin
            if (!w_dv[V_W-1]) begin
                n_vx = w_dv + w_sv;
                n_vy = w_b2;
            end else begin
                n_vx = w_b2;
                n_vy = w_sv - w_dv;
            end
        end else begin
            if (!w_dv[V_W-1]) begin
                n_vx = w_b2;
                n_vy = -(w_dv + w_sv);
            end else begin
                n_vx = w_dv - w_sv;
                n_vy = w_b2;
            end
        end
    end

    logic r_v_vld;
    logic signed [V_W-1:0] r_v_vx, r_v_vy;
    t_pay r_v_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_vld <= 1'b0;
        else if (w_adv) r_v_vld <= w_sq_vld;
        if (w_adv) begin
            r_v_vx  <= n_vx;
            r_v_vy  <= n_vy;
            r_v_pay <= w_sq_pay;
        end
    end

    // normalize stage: shift both magnitudes below 2^16
    logic [V_W-2:0]  w_ax, w_ay, w_m;
    logic [SH_W-1:0] w_sh;
    logic [NV_W-1:0] w_nax, w_nay;
    logic signed [NV_W:0] w_nvx, w_nvy;

    assign w_ax = (V_W-1)'(r_v_vx[V_W-1] ? -r_v_vx : r_v_vx);
    assign w_ay = (V_W-1)'(r_v_vy[V_W-1] ? -r_v_vy : r_v_vy);
    assign w_m  = w_ax | w_ay;

    always_comb begin
        w_sh = '0;
        for (int j = 0; j < V_W - 1 - NV_W; j++) begin
            if (w_m[NV_W+j]) w_sh = SH_W'(j + 1);
        end
    end

    assign w_nax = NV_W'(w_ax >> w_sh);
    assign w_nay = NV_W'(w_ay >> w_sh);
    assign w_nvx = r_v_vx[V_W-1] ? -$signed({1'b0, w_nax}) : $signed({1'b0, w_nax});
    assign w_nvy = r_v_vy[V_W-1] ? -$signed({1'b0, w_nay}) : $signed({1'b0, w_nay});

    logic r_n_vld;
    logic signed [NV_W:0] r_n_vx, r_n_vy;
    logic [NV_W-1:0] r_n_ax, r_n_ay;
    t_pay r_n_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_n_vld <= 1'b0;
        else if (w_adv) r_n_vld <= r_v_vld;
        if (w_adv) begin
            r_n_vx  <= w_nvx;
            r_n_vy  <= w_nvy;
            r_n_ax  <= w_nax;
            r_n_ay  <= w_nay;
            r_n_pay <= r_v_pay;
        end
    end

    // product stage: vector squares and v*g
    logic r_p_vld;
    logic signed [SQ_W-1:0] r_p_xx, r_p_xy, r_p_yy;
    logic signed [PG_W-1:0] r_p_px, r_p_py;
    logic [NV_W-1:0] r_p_ax, r_p_ay;
    t_pay r_p_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_vld <= 1'b0;
        else if (w_adv) r_p_vld <= r_n_vld;
        if (w_adv) begin
            r_p_xx  <= r_n_vx * r_n_vx;
            r_p_xy  <= r_n_vx * r_n_vy;
            r_p_yy  <= r_n_vy * r_n_vy;
            r_p_px  <= r_n_vx * r_n_pay.gx;
            r_p_py  <= r_n_vy * r_n_pay.gy;
            r_p_ax  <= r_n_ax;
            r_p_ay  <= r_n_ay;
            r_p_pay <= r_n_pay;
        end
    end

    // hessian term stage
    logic r_q_vld;
    logic signed [P_W-1:0]  r_q_p;
    logic signed [QT_W-1:0] r_q_qa, r_q_qb, r_q_qc;
    logic [NV_W-1:0] r_q_ax, r_q_ay;
    logic [COORD_WIDTH-1:0] r_q_col, r_q_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_vld <= 1'b0;
        else if (w_adv) r_q_vld <= r_p_vld;
        if (w_adv) begin
            r_q_p   <= P_W'(r_p_px) + P_W'(r_p_py);
            r_q_qa  <= r_p_pay.a * r_p_xx;
            r_q_qb  <= r_p_pay.b * r_p_xy;
            r_q_qc  <= r_p_pay.c * r_p_yy;
            r_q_ax  <= r_p_ax;
            r_q_ay  <= r_p_ay;
            r_q_col <= r_p_pay.col;
            r_q_row <= r_p_pay.row;
        end
    end

    // denominator and magnitudes
    logic signed [Q_W-1:0] w_q;
    logic signed [P_W-1:0] w_pneg;

    assign w_q    = Q_W'(r_q_qa) + (Q_W'(r_q_qb) <<< 1) + Q_W'(r_q_qc);
    assign w_pneg = -r_q_p;

    logic r_r_vld, r_r_qz;
    logic [AQ_W-1:0] r_r_aq;
    logic [AP_W-1:0] r_r_ap;
    logic [NV_W-1:0] r_r_ax, r_r_ay;
    logic [COORD_WIDTH-1:0] r_r_col, r_r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_r_vld <= 1'b0;
        else if (w_adv) r_r_vld <= r_q_vld;
        if (w_adv) begin
            r_r_qz  <= (w_q == '0);
            r_r_aq  <= AQ_W'(w_q[Q_W-1] ? -w_q : w_q);
            r_r_ap  <= AP_W'(r_q_p[P_W-1] ? w_pneg : r_q_p);
            r_r_ax  <= r_q_ax;
            r_r_ay  <= r_q_ay;
            r_r_col <= r_q_col;
            r_r_row <= r_q_row;
        end
    end

    // limit products
    logic r_t_vld, r_t_qz;
    logic [EX_W-1:0]  r_t_ex, r_t_ey;
    logic [LIM_W-1:0] r_t_lim;
    logic [COORD_WIDTH-1:0] r_t_col, r_t_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_t_vld <= 1'b0;
        else if (w_adv) r_t_vld <= r_r_vld;
        if (w_adv) begin
            r_t_qz  <= r_r_qz;
            r_t_ex  <= r_r_ap * r_r_ax;
            r_t_ey  <= r_r_ap * r_r_ay;
            r_t_lim <= r_cfg_limit * r_r_aq;
            r_t_col <= r_r_col;
            r_t_row <= r_r_row;
        end
    end

    // offset test and output register
    logic w_ok;
    assign w_ok = !r_t_qz
               && (LIM_W'({r_t_ex, LIMIT_FRAC'(0)}) <= r_t_lim)
               && (LIM_W'({r_t_ey, LIMIT_FRAC'(0)}) <= r_t_lim);

    logic [COORD_WIDTH-1:0] r_out_col, r_out_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_adv) r_out_valid <= r_t_vld && w_ok;
        if (w_adv) begin
            r_out_col <= r_t_col;
            r_out_row <= r_t_row;
        end
    end

    assign o_pt.valid   = r_out_valid;
    assign o_pt.out_col = r_out_col;
    assign o_pt.out_row = r_out_row;

endmodule
`default_nettype wire

>>> src/slpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpt_checker
// Port-level checks of the line point test, bound to the top level.
// ----------------------------------------------------------------------------
module slpt_checker import slpt_pkg::*; (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_pix_ready,
    input wire                   i_pt_valid,
    input wire                   i_pt_ready,
    input wire [COORD_WIDTH-1:0] i_out_col,
    input wire [COORD_WIDTH-1:0] i_out_row
);

    // a stalled word stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt_valid && !i_pt_ready |=> i_pt_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its coordinates
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt_valid && !i_pt_ready |=> $stable(i_out_col) && $stable(i_out_row))
        else $error("output word changed while stalled");

    // input is taken whenever the output side is free
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt_valid |-> i_pix_ready)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pt_valid)
        else $error("output word after reset");

endmodule

bind steger_line_point_test slpt_checker u_slpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_pt_valid  (o_pt.valid),
    .i_pt_ready  (o_pt.ready),
    .i_out_col   (o_pt.out_col),
    .i_out_row   (o_pt.out_row)
);
`default_nettype wire
